// ----- sv/assert_macros.svh -----
// Assertion macros shared by the split unit's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, c, r, p, msg) \
    lbl: assert property (@(posedge c) disable iff (!(r)) (p)) else $error(msg);
// Condition in one cycle implies a condition in the following cycle.
`define ASSERT_NEXT(lbl, c, r, a, b, msg) \
    lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, c, r, p, msg)
`define ASSERT_NEXT(lbl, c, r, a, b, msg)
`endif
`endif

// ----- sv/ptss_pkg.sv -----
// Shared types and constants of the prime two-square split unit.
package ptss_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int Z_W     = LIMIT_W + 1;
    localparam int ADDR_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd256;
    localparam logic [Z_W-1:0]     WITNESS_FIRST = 17'd2;
    localparam logic               REG_WITNESS_LIMIT = 1'b0;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ZMOD_START,
        CMD_POW_INIT,
        CMD_MUL_ACC_START,
        CMD_ACC_TAKE,
        CMD_MUL_SQ_START,
        CMD_BASE_TAKE,
        CMD_CHK_START,
        CMD_EUC_INIT,
        CMD_BSQ,
        CMD_EUC_DIV_START,
        CMD_EUC_TAKE,
        CMD_SQRT_START,
        CMD_YSQ,
        CMD_NEXT_Z,
        CMD_OUT_OK,
        CMD_OUT_TWO,
        CMD_OUT_FAIL
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLASSIFY,
        S_ZCHK,
        S_ZMOD_W,
        S_POW,
        S_MACC_W,
        S_SQ_ST,
        S_MSQ_W,
        S_CHK_W,
        S_EUC_SQ,
        S_EUC_TEST,
        S_EDIV_W,
        S_SQRT_W,
        S_PAIR,
        S_OUT_OK,
        S_OUT_TWO,
        S_OUT_FAIL
    } state_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic sqrt_busy;
        logic ex_zero;
        logic ex_odd;
        logic chk_ok;
        logic b_zero;
        logic b_gt;
        logic pair_ok;
        logic z_over;
        logic p_two;
        logic p_zero;
    } dp_status_t;

endpackage

// ----- sv/ptss_datapath.sv -----
// Datapath: modular multiplier, remainder unit, square root unit and operand registers.
module ptss_datapath
    import ptss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [WORD_W-1:0]   prime_in,
    input  logic [LIMIT_W-1:0]  witness_limit,
    output dp_status_t          sts,
    output logic [HALF_W-1:0]   root_first,
    output logic [HALF_W-1:0]   root_second,
    output logic                found
);

    logic [WORD_W-1:0] p_reg, p_next;
    logic [Z_W-1:0]    z_reg, z_next;
    logic [WORD_W-1:0] ex_reg, ex_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] num_reg, num_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] bsq_reg, bsq_next;
    logic [WORD_W-1:0] ysq_reg, ysq_next;

    logic [WORD_W-1:0] mx_reg, mx_next;
    logic [WORD_W-1:0] my_reg, my_next;
    logic [WORD_W-1:0] mres_reg, mres_next;
    logic [5:0]        mcnt_reg, mcnt_next;
    logic              mph_reg, mph_next;
    logic              mbusy_reg, mbusy_next;

    logic [WORD_W-1:0] dq_reg, dq_next;
    logic [WORD_W-1:0] dd_reg, dd_next;
    logic [WORD_W-1:0] drem_reg, drem_next;
    logic [5:0]        dcnt_reg, dcnt_next;
    logic              dbusy_reg, dbusy_next;

    logic [WORD_W-1:0] sv_reg, sv_next;
    logic [WORD_W-1:0] sres_reg, sres_next;
    logic [WORD_W-1:0] sbit_reg, sbit_next;
    logic [4:0]        scnt_reg, scnt_next;
    logic              sbusy_reg, sbusy_next;

    logic [HALF_W-1:0] rf_reg, rf_next;
    logic [HALF_W-1:0] rs_reg, rs_next;
    logic              fd_reg, fd_next;

    logic [WORD_W-1:0] add_b, gap, mod_sum, chk_x;
    logic [WORD_W:0]   trial, trial_sub;
    logic              trial_ge;
    logic [WORD_W-1:0] s_sum;
    logic [WORD_W-1:0] bsq_prod, ysq_prod;

    // Modular add of the doubling or the addend step
    always_comb
    begin
        add_b   = mph_reg ? mx_reg : mres_reg;
        gap     = p_reg - add_b;
        mod_sum = (mres_reg >= gap) ? (mres_reg - gap) : (mres_reg + add_b);
    end

    // Restoring remainder step, one dividend bit a cycle
    always_comb
    begin
        trial     = {drem_reg, dq_reg[WORD_W-1]};
        trial_ge  = trial >= {1'b0, dd_reg};
        trial_sub = trial - {1'b0, dd_reg};
    end

    assign s_sum    = sres_reg + sbit_reg;
    assign bsq_prod = b_reg[HALF_W-1:0] * b_reg[HALF_W-1:0];
    assign ysq_prod = sres_reg[HALF_W-1:0] * sres_reg[HALF_W-1:0];
    // For a modulus of one the operand reduces to zero
    assign chk_x    = (p_reg == 64'd1) ? '0 : acc_reg;

    // Next values for every register
    always_comb
    begin
        p_next = p_reg;       z_next = z_reg;       ex_next = ex_reg;
        acc_next = acc_reg;   base_next = base_reg; num_next = num_reg;
        b_next = b_reg;       bsq_next = bsq_reg;   ysq_next = ysq_reg;
        mx_next = mx_reg;     my_next = my_reg;     mres_next = mres_reg;
        mcnt_next = mcnt_reg; mph_next = mph_reg;   mbusy_next = mbusy_reg;
        dq_next = dq_reg;     dd_next = dd_reg;     drem_next = drem_reg;
        dcnt_next = dcnt_reg; dbusy_next = dbusy_reg;
        sv_next = sv_reg;     sres_next = sres_reg; sbit_next = sbit_reg;
        scnt_next = scnt_reg; sbusy_next = sbusy_reg;
        rf_next = rf_reg;     rs_next = rs_reg;     fd_next = fd_reg;

        // Advance the multiplier
        if (mbusy_reg)
        begin
            if (!mph_reg)
            begin
                mres_next = mod_sum;
                mph_next  = 1'b1;
            end
            else
            begin
                if (my_reg[mcnt_reg])
                    mres_next = mod_sum;
                mph_next = 1'b0;
                if (mcnt_reg == 6'd0)
                    mbusy_next = 1'b0;
                else
                    mcnt_next = mcnt_reg - 6'd1;
            end
        end

        // Advance the remainder unit
        if (dbusy_reg)
        begin
            drem_next = trial_ge ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
            dq_next   = {dq_reg[WORD_W-2:0], 1'b0};
            if (dcnt_reg == 6'd0)
                dbusy_next = 1'b0;
            else
                dcnt_next = dcnt_reg - 6'd1;
        end

        // Advance the square root unit
        if (sbusy_reg)
        begin
            if (sv_reg >= s_sum)
            begin
                sv_next   = sv_reg - s_sum;
                sres_next = (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_next = sres_reg >> 1;
            sbit_next = sbit_reg >> 2;
            if (scnt_reg == 5'd0)
                sbusy_next = 1'b0;
            else
                scnt_next = scnt_reg - 5'd1;
        end

        case (cmd) inside
            CMD_LOAD:
            begin
                p_next = prime_in;
                z_next = WITNESS_FIRST;
            end
            CMD_ZMOD_START, CMD_EUC_DIV_START:
            begin
                dq_next    = (cmd == CMD_ZMOD_START) ? {{(WORD_W-Z_W){1'b0}}, z_reg} : num_reg;
                dd_next    = (cmd == CMD_ZMOD_START) ? p_reg : b_reg;
                drem_next  = '0;
                dcnt_next  = 6'd63;
                dbusy_next = 1'b1;
            end
            CMD_POW_INIT:
            begin
                base_next = drem_reg;
                acc_next  = 64'd1;
                ex_next   = (p_reg - 64'd1) >> 2;
            end
            CMD_MUL_ACC_START, CMD_MUL_SQ_START, CMD_CHK_START:
            begin
                mx_next    = (cmd == CMD_MUL_ACC_START) ? acc_reg :
                             (cmd == CMD_CHK_START) ? chk_x : base_reg;
                my_next    = (cmd == CMD_CHK_START) ? chk_x : base_reg;
                mres_next  = '0;
                mcnt_next  = 6'd63;
                mph_next   = 1'b0;
                mbusy_next = 1'b1;
            end
            CMD_ACC_TAKE:
                acc_next = mres_reg;
            CMD_BASE_TAKE:
            begin
                base_next = mres_reg;
                ex_next   = ex_reg >> 1;
            end
            CMD_EUC_INIT:
            begin
                num_next = p_reg;
                b_next   = acc_reg;
            end
            CMD_BSQ:
                bsq_next = bsq_prod;
            CMD_EUC_TAKE:
            begin
                num_next = b_reg;
                b_next   = drem_reg;
            end
            CMD_SQRT_START:
            begin
                sv_next    = p_reg - bsq_reg;
                sres_next  = '0;
                sbit_next  = 64'h4000_0000_0000_0000;
                scnt_next  = 5'd31;
                sbusy_next = 1'b1;
            end
            CMD_YSQ:
                ysq_next = ysq_prod;
            CMD_NEXT_Z:
                z_next = z_reg + 17'd1;
            CMD_OUT_OK:
            begin
                rf_next = b_reg[HALF_W-1:0];
                rs_next = sres_reg[HALF_W-1:0];
                fd_next = 1'b1;
            end
            CMD_OUT_TWO:
            begin
                rf_next = 32'd1;
                rs_next = 32'd1;
                fd_next = 1'b1;
            end
            CMD_OUT_FAIL:
            begin
                rf_next = '0;
                rs_next = '0;
                fd_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Hold unit busy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            sbusy_reg <= 1'b0;
        end
        else
        begin
            mbusy_reg <= mbusy_next;
            dbusy_reg <= dbusy_next;
            sbusy_reg <= sbusy_next;
        end
    end

    // Hold operands and results
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;       z_reg <= z_next;       ex_reg <= ex_next;
        acc_reg <= acc_next;   base_reg <= base_next; num_reg <= num_next;
        b_reg <= b_next;       bsq_reg <= bsq_next;   ysq_reg <= ysq_next;
        mx_reg <= mx_next;     my_reg <= my_next;     mres_reg <= mres_next;
        mcnt_reg <= mcnt_next; mph_reg <= mph_next;
        dq_reg <= dq_next;     dd_reg <= dd_next;     drem_reg <= drem_next;
        dcnt_reg <= dcnt_next;
        sv_reg <= sv_next;     sres_reg <= sres_next; sbit_reg <= sbit_next;
        scnt_reg <= scnt_next;
        rf_reg <= rf_next;     rs_reg <= rs_next;     fd_reg <= fd_next;
    end

    // Report status to the controller
    always_comb
    begin
        sts.mul_busy  = mbusy_reg;
        sts.div_busy  = dbusy_reg;
        sts.sqrt_busy = sbusy_reg;
        sts.ex_zero   = (ex_reg == '0);
        sts.ex_odd    = ex_reg[0];
        sts.chk_ok    = (mres_reg == (p_reg - 64'd1));
        sts.b_zero    = (b_reg == '0);
        sts.b_gt      = (b_reg[WORD_W-1:HALF_W] != '0) || (bsq_reg > p_reg);
        sts.pair_ok   = ((ysq_reg + bsq_reg) == p_reg);
        sts.z_over    = (z_reg > {1'b0, witness_limit});
        sts.p_two     = (p_reg == 64'd2);
        sts.p_zero    = (p_reg == '0);
    end

    assign root_first  = rf_reg;
    assign root_second = rs_reg;
    assign found       = fd_reg;

endmodule

// ----- sv/ptss_ctrl.sv -----
// Controller: sequences witnesses, powering, Euclid steps and the result item.
`include "assert_macros.svh"
module ptss_ctrl
    import ptss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_CLASSIFY;
                end
            S_CLASSIFY:
                if (sts.p_two)
                    state_next = S_OUT_TWO;
                else if (sts.p_zero)
                    state_next = S_OUT_FAIL;
                else
                    state_next = S_ZCHK;
            S_ZCHK:
                if (sts.z_over)
                    state_next = S_OUT_FAIL;
                else
                begin
                    cmd        = CMD_ZMOD_START;
                    state_next = S_ZMOD_W;
                end
            S_ZMOD_W:
                if (!sts.div_busy)
                begin
                    cmd        = CMD_POW_INIT;
                    state_next = S_POW;
                end
            S_POW:
                if (sts.ex_zero)
                begin
                    cmd        = CMD_CHK_START;
                    state_next = S_CHK_W;
                end
                else if (sts.ex_odd)
                begin
                    cmd        = CMD_MUL_ACC_START;
                    state_next = S_MACC_W;
                end
                else
                begin
                    cmd        = CMD_MUL_SQ_START;
                    state_next = S_MSQ_W;
                end
            S_MACC_W:
                if (!sts.mul_busy)
                begin
                    cmd        = CMD_ACC_TAKE;
                    state_next = S_SQ_ST;
                end
            S_SQ_ST:
            begin
                cmd        = CMD_MUL_SQ_START;
                state_next = S_MSQ_W;
            end
            S_MSQ_W:
                if (!sts.mul_busy)
                begin
                    cmd        = CMD_BASE_TAKE;
                    state_next = S_POW;
                end
            S_CHK_W:
                if (!sts.mul_busy)
                begin
                    if (sts.chk_ok)
                    begin
                        cmd        = CMD_EUC_INIT;
                        state_next = S_EUC_SQ;
                    end
                    else
                    begin
                        cmd        = CMD_NEXT_Z;
                        state_next = S_ZCHK;
                    end
                end
            S_EUC_SQ:
            begin
                cmd        = CMD_BSQ;
                state_next = S_EUC_TEST;
            end
            S_EUC_TEST:
                if (sts.b_zero || !sts.b_gt)
                begin
                    cmd        = CMD_SQRT_START;
                    state_next = S_SQRT_W;
                end
                else
                begin
                    cmd        = CMD_EUC_DIV_START;
                    state_next = S_EDIV_W;
                end
            S_EDIV_W:
                if (!sts.div_busy)
                begin
                    cmd        = CMD_EUC_TAKE;
                    state_next = S_EUC_SQ;
                end
            S_SQRT_W:
                if (!sts.sqrt_busy)
                begin
                    cmd        = CMD_YSQ;
                    state_next = S_PAIR;
                end
            S_PAIR:
                if (sts.pair_ok)
                    state_next = S_OUT_OK;
                else
                begin
                    cmd        = CMD_NEXT_Z;
                    state_next = S_ZCHK;
                end
            S_OUT_OK:
                if (slot_free)
                begin
                    cmd        = CMD_OUT_OK;
                    state_next = S_IDLE;
                end
            S_OUT_TWO:
                if (slot_free)
                begin
                    cmd        = CMD_OUT_TWO;
                    state_next = S_IDLE;
                end
            S_OUT_FAIL:
                if (slot_free)
                begin
                    cmd        = CMD_OUT_FAIL;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Raise the result item on loading, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd == CMD_OUT_OK || cmd == CMD_OUT_TWO || cmd == CMD_OUT_FAIL)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "accepted item did not start")
    `ASSERT_ALWAYS(a_out_slot, clk, rst_n, !(cmd == CMD_OUT_OK || cmd == CMD_OUT_TWO || cmd == CMD_OUT_FAIL) || slot_free, "result loaded over a waiting item")
    `ASSERT_ALWAYS(a_pow_units_idle, clk, rst_n, (state_reg != S_POW) || (!sts.mul_busy && !sts.div_busy), "powering step while a unit runs")
    `ASSERT_NEXT(a_z_step, clk, rst_n, cmd == CMD_NEXT_Z, state_reg == S_ZCHK, "witness advance without limit check")

endmodule

// ----- sv/prime_two_square_split_unit.sv -----
// Top level of the prime two-square split unit: register port, controller and datapath.
//
//  channel   direction  signals
//  input     in         in_valid, in_ready, prime_in
//  result    out        out_valid, out_ready, root_first, root_second, found
//  config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item at a time. Each witness costs a reduction of z, then per exponent bit one or
// two modular products (bit-serial double-and-add multiplier), a check, Euclid steps
// (restoring remainder unit) and a square root.
// The result register lets a new item be taken while the last result waits.
// Reset sets witness_limit to 256 and empties the result register; no clearing pass.
`include "assert_macros.svh"
module prime_two_square_split_unit
    import ptss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [WORD_W-1:0]  prime_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [HALF_W-1:0]  root_first,
    output logic [HALF_W-1:0]  root_second,
    output logic               found,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               wr_en;
    cmd_t               cmd;
    dp_status_t         sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the witness limit
    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en && (paddr[2] == REG_WITNESS_LIMIT))
            limit_next = pwdata[LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_WITNESS_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, limit_reg};
            default:           prdata = '0;
        endcase
    end

    ptss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptss_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .prime_in      (prime_in),
        .witness_limit (limit_reg),
        .sts           (sts),
        .root_first    (root_first),
        .root_second   (root_second),
        .found         (found)
    );

    `ASSERT_NEXT(a_cfg_write, clk, rst_n, wr_en && (paddr[2] == REG_WITNESS_LIMIT), limit_reg == $past(pwdata[LIMIT_W-1:0]), "witness limit write lost")
    `ASSERT_ALWAYS(a_fail_zero, clk, rst_n, !out_valid || found || (root_first == '0 && root_second == '0), "failed item carries roots")
    `ASSERT_ALWAYS(a_busy_no_take, clk, rst_n, !(in_ready && (sts.mul_busy || sts.div_busy || sts.sqrt_busy)), "ready while a unit runs")

endmodule
